>>> hdl/pes_pkg.sv
// shared types and codes of the periodic event scheduler
`timescale 1ns / 1ps
package pes_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DefMaxFires = 64;

  typedef enum logic [1:0] {
    REQ_SCHEDULE = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_ADVANCE  = 2'd2,
    REQ_RUN      = 2'd3
  } pes_req_e;

  typedef enum logic [2:0] {
    ST_SCHEDULED  = 3'd0,
    ST_CANCEL_OK  = 3'd1,
    ST_CANCEL_REF = 3'd2,
    ST_FIRED      = 3'd3,
    ST_RUN_DONE   = 3'd4,
    ST_FULL       = 3'd5,
    ST_BAD_PERIOD = 3'd6,
    ST_ADVANCED   = 3'd7
  } pes_status_e;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_MARK   = 2'd2,
    ACT_REARM  = 2'd3
  } pes_act_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_APPLY,
    S_EMIT
  } pes_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] first_delay;
    logic        delay_given;
    logic [31:0] period;
    logic        periodic;
    logic [31:0] handle;
    logic [31:0] cycles;
  } pes_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_handle;
    logic [63:0] now;
    logic        more_pending;
    logic        last;
  } pes_out_t;

  // payload of one table entry, the valid mark travels beside it
  typedef struct packed {
    logic [63:0] due;
    logic [31:0] handle;
    logic [31:0] period;
    logic        periodic;
    logic        cancelled;
  } pes_entry_t;

endpackage

>>> hdl/pes_cell.sv
// one cell of the rotating entry ring
`timescale 1ns / 1ps
module pes_cell #(
  parameter int unsigned SLOT_W    = 6,
  parameter int unsigned INIT_SLOT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                valid_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  pes_pkg::pes_entry_t entry_i,
  output logic                valid_o,
  output logic [SLOT_W-1:0]   slot_o,
  output pes_pkg::pes_entry_t entry_o
);
  import pes_pkg::*;

  logic              valid_q;
  logic [SLOT_W-1:0] slot_q;
  pes_entry_t        entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= SLOT_W'(INIT_SLOT);
    end else if (shift_i) begin
      valid_q <= valid_i;
      slot_q  <= slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;
  assign entry_o = entry_q;

endmodule

>>> hdl/periodic_event_scheduler_core.sv
// top level of the periodic event scheduler: entry ring and request sequencer
`timescale 1ns / 1ps
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (pes_in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (pes_out_t)
//
// the entries sit in a ring of CAPACITY cells that rotates one place a cycle
// while the sequencer scans or applies; the sequencer looks only at the head
// cell, so one full turn brings every cell past it. advance and a rejected zero
// period go straight to the result without a turn. schedule and cancel take a
// search turn and an update turn; a full table or a refused cancel skips the
// update turn. run takes a search turn and an update turn for each due entry
// it handles, plus a closing search turn.
// reset empties the table at once (valid marks only), clock 0, handle 1.
// a full output register stalls the sequencer wherever it must hand an item on.
module periodic_event_scheduler_core
  import pes_pkg::*;
#(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned MAX_FIRES = DefMaxFires
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pes_pkg::pes_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pes_pkg::pes_out_t out_data_o
);

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned FireW = $clog2(MAX_FIRES + 1);
  localparam logic [SlotW-1:0] LastPos = SlotW'(CAPACITY - 1);
  localparam logic [FireW-1:0] FireMax = FireW'(MAX_FIRES);

  // ring of cells, the head is cell 0
  logic             cell_vld  [CAPACITY];
  logic [SlotW-1:0] cell_slot [CAPACITY];
  pes_entry_t       cell_ent  [CAPACITY];
  logic             ring_shift;
  logic             tail_vld;
  pes_entry_t       tail_ent;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_tail
      pes_cell #(.SLOT_W(SlotW), .INIT_SLOT(g)) u_cell (
        .clk_i, .rst_ni, .shift_i(ring_shift),
        .valid_i(tail_vld), .slot_i(cell_slot[0]), .entry_i(tail_ent),
        .valid_o(cell_vld[g]), .slot_o(cell_slot[g]), .entry_o(cell_ent[g])
      );
    end else begin : g_body
      pes_cell #(.SLOT_W(SlotW), .INIT_SLOT(g)) u_cell (
        .clk_i, .rst_ni, .shift_i(ring_shift),
        .valid_i(cell_vld[g+1]), .slot_i(cell_slot[g+1]), .entry_i(cell_ent[g+1]),
        .valid_o(cell_vld[g]), .slot_o(cell_slot[g]), .entry_o(cell_ent[g])
      );
    end
  end

  // control and request state
  pes_state_e       state_q, state_d;
  pes_in_t          req_q;
  logic [63:0]      clock_q;
  logic [31:0]      next_handle_q;
  logic [SlotW-1:0] pos_q;
  pes_out_t         res_q;
  pes_act_e         act_q;
  logic [SlotW-1:0] target_q;
  logic             scan_after_q;
  logic [FireW-1:0] fires_q;
  logic             pend_q;
  logic [31:0]      pend_handle_q;
  logic             out_valid_q;
  pes_out_t         out_q;

  // search results of one turn
  logic             best_found_q, free_found_q, match_found_q;
  pes_entry_t       best_q;
  logic [SlotW-1:0] best_slot_q, free_slot_q, match_slot_q;
  logic             match_canc_q;

  logic       out_space;
  logic       in_acc;
  logic       turn_end;
  pes_entry_t ins_ent;

  assign out_space  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign turn_end   = (pos_q == LastPos);
  assign ring_shift = (state_q == S_SCAN) || (state_q == S_APPLY);

  // new entry built from the request, handle as granted in the result
  always_comb begin
    ins_ent.due       = clock_q + 64'(req_q.delay_given ? req_q.first_delay : req_q.period);
    ins_ent.handle    = res_q.out_handle;
    ins_ent.period    = req_q.period;
    ins_ent.periodic  = req_q.periodic;
    ins_ent.cancelled = 1'b0;
  end

  // head update on its way to the tail
  always_comb begin
    tail_vld = cell_vld[0];
    tail_ent = cell_ent[0];
    if (state_q == S_APPLY && cell_slot[0] == target_q) begin
      case (act_q)
        ACT_INSERT: begin
          tail_vld = 1'b1;
          tail_ent = ins_ent;
        end
        ACT_REMOVE: tail_vld = 1'b0;
        ACT_MARK:   tail_ent.cancelled = 1'b1;
        ACT_REARM:  tail_ent.due = cell_ent[0].due + 64'(cell_ent[0].period);
        default:    tail_vld = cell_vld[0];
      endcase
    end
  end

  // decision after a search turn
  logic             dec_wait, dec_apply, dec_scan_after, dec_take_handle;
  logic             dec_fire, dec_emit_pend;
  pes_act_e         dec_act;
  logic [SlotW-1:0] dec_target;
  pes_out_t         dec_res;

  always_comb begin
    dec_wait        = 1'b0;
    dec_apply       = 1'b0;
    dec_scan_after  = 1'b0;
    dec_take_handle = 1'b0;
    dec_fire        = 1'b0;
    dec_emit_pend   = 1'b0;
    dec_act         = ACT_REMOVE;
    dec_target      = best_slot_q;
    dec_res         = '0;
    dec_res.last    = 1'b1;
    case (pes_req_e'(req_q.req_type))
      REQ_SCHEDULE: begin
        if (!free_found_q) begin
          dec_res.status = ST_FULL;
        end else begin
          dec_apply          = 1'b1;
          dec_act            = ACT_INSERT;
          dec_target         = free_slot_q;
          dec_take_handle    = 1'b1;
          dec_res.status     = ST_SCHEDULED;
          dec_res.out_handle = next_handle_q;
        end
      end
      REQ_CANCEL: begin
        dec_res.status = ST_CANCEL_REF;
        if (req_q.handle != 32'd0 && best_found_q) begin
          if (best_q.handle == req_q.handle) begin
            dec_apply      = 1'b1;
            dec_res.status = ST_CANCEL_OK;
          end else if (match_found_q && !match_canc_q) begin
            dec_apply      = 1'b1;
            dec_act        = ACT_MARK;
            dec_target     = match_slot_q;
            dec_res.status = ST_CANCEL_OK;
          end
        end
      end
      REQ_RUN: begin
        if (!best_found_q || best_q.due > clock_q) begin
          dec_res.status = ST_RUN_DONE;
        end else if (best_q.cancelled) begin
          // marked entry falls due: dropped without a result
          dec_apply      = 1'b1;
          dec_scan_after = 1'b1;
        end else if (fires_q >= FireMax) begin
          dec_res.more_pending = 1'b1;
        end else begin
          dec_wait       = pend_q && !out_space;
          dec_emit_pend  = pend_q && out_space;
          dec_fire       = !dec_wait;
          dec_apply      = 1'b1;
          dec_scan_after = 1'b1;
          dec_act        = best_q.periodic ? ACT_REARM : ACT_REMOVE;
        end
        // final result of the run carries the held firing if there is one
        if (!dec_apply && pend_q) begin
          dec_res.status     = ST_FIRED;
          dec_res.out_handle = pend_handle_q;
        end
      end
      default: dec_res.status = ST_ADVANCED;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (pes_req_e'(in_data_i.req_type) == REQ_ADVANCE ||
              (pes_req_e'(in_data_i.req_type) == REQ_SCHEDULE &&
               in_data_i.periodic && in_data_i.period == 32'd0)) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN:   if (turn_end) state_d = S_DECIDE;
      S_DECIDE: begin
        if (!dec_wait) state_d = dec_apply ? S_APPLY : S_EMIT;
      end
      S_APPLY:  if (turn_end) state_d = scan_after_q ? S_SCAN : S_EMIT;
      S_EMIT:   if (out_space) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // output register load
  logic     emit_en;
  pes_out_t emit_val;

  always_comb begin
    emit_en  = 1'b0;
    emit_val = res_q;
    if (state_q == S_EMIT && out_space) begin
      emit_en = 1'b1;
    end else if (state_q == S_DECIDE && dec_emit_pend) begin
      emit_en             = 1'b1;
      emit_val            = '0;
      emit_val.status     = ST_FIRED;
      emit_val.out_handle = pend_handle_q;
    end
    emit_val.now = clock_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      clock_q       <= '0;
      next_handle_q <= 32'd1;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
      pend_q        <= 1'b0;
      fires_q       <= '0;
      scan_after_q  <= 1'b0;
      act_q         <= ACT_REMOVE;
    end else begin
      state_q <= state_d;
      pos_q   <= ring_shift ? (turn_end ? '0 : pos_q + 1'b1) : '0;
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        pend_q  <= 1'b0;
        fires_q <= '0;
        if (pes_req_e'(in_data_i.req_type) == REQ_ADVANCE) begin
          clock_q <= clock_q + 64'(in_data_i.cycles);
        end
      end
      if (state_q == S_DECIDE && !dec_wait) begin
        act_q        <= dec_act;
        scan_after_q <= dec_scan_after;
        if (dec_take_handle) begin
          next_handle_q <= (next_handle_q == 32'hFFFF_FFFF) ? 32'd1 : next_handle_q + 32'd1;
        end
        if (dec_fire) begin
          pend_q  <= 1'b1;
          fires_q <= fires_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      out_q <= emit_val;
    end
    if (in_acc) begin
      req_q       <= in_data_i;
      res_q       <= '0;
      res_q.last  <= 1'b1;
      res_q.status <= (pes_req_e'(in_data_i.req_type) == REQ_ADVANCE) ?
                      ST_ADVANCED : ST_BAD_PERIOD;
    end
    if (state_q == S_DECIDE && !dec_wait) begin
      res_q    <= dec_res;
      target_q <= dec_target;
      if (dec_fire) begin
        pend_handle_q <= best_q.handle;
      end
    end
    // search over the head cell, first place of a turn starts afresh
    if (state_q == S_SCAN) begin
      if (cell_vld[0] && (pos_q == '0 || !best_found_q ||
          cell_ent[0].due < best_q.due ||
          (cell_ent[0].due == best_q.due && cell_ent[0].handle < best_q.handle))) begin
        best_q      <= cell_ent[0];
        best_slot_q <= cell_slot[0];
      end
      best_found_q <= cell_vld[0] || (pos_q != '0 && best_found_q);
      if (!cell_vld[0] && (pos_q == '0 || !free_found_q || cell_slot[0] < free_slot_q)) begin
        free_slot_q <= cell_slot[0];
      end
      free_found_q <= !cell_vld[0] || (pos_q != '0 && free_found_q);
      if (cell_vld[0] && cell_ent[0].handle == req_q.handle &&
          (pos_q == '0 || !match_found_q || cell_slot[0] < match_slot_q)) begin
        match_slot_q  <= cell_slot[0];
        match_canc_q  <= cell_ent[0].cancelled;
        match_found_q <= 1'b1;
      end else if (pos_q == '0) begin
        match_found_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
